// ----- design/tag_pkg.sv -----
// Shared types, widths, codes and small arithmetic helpers for the tile
// activation grid engine. No dependencies.
package tag_pkg;

   localparam int DEF_MAX_ROWS = 128;
   localparam int DEF_MAX_COLS = 128;

   localparam int TS_W      = 9;
   localparam int THR_W     = 17;
   localparam int MODE_W    = 2;
   localparam int ITER_W    = 6;
   localparam int MOVE_W    = 16;
   localparam int AUD_W     = 17;
   localparam int DIM_W     = 13;
   localparam int ACT_W     = 17;
   localparam int CH_W      = 8;
   localparam int IDX_W     = 7;
   localparam int CORNER_W  = 12;
   localparam int CSR_W     = 17;
   localparam int CSR_IDX_W = 3;
   localparam int SUM_W     = 20;

   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_RUN  = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   localparam logic [1:0] RSP_LOADED    = 2'd0;
   localparam logic [1:0] RSP_RUN_DONE  = 2'd1;
   localparam logic [1:0] RSP_TILE      = 2'd2;
   localparam logic [1:0] RSP_BAD_INDEX = 2'd3;

   localparam logic [1:0] MODE_VERT = 2'd0;
   localparam logic [1:0] MODE_FOUR = 2'd1;
   localparam logic [1:0] MODE_HORZ = 2'd2;

   localparam logic [2:0] CSR_TILE_SIZE  = 3'd0;
   localparam logic [2:0] CSR_THRESHOLD  = 3'd1;
   localparam logic [2:0] CSR_MODE       = 3'd2;
   localparam logic [2:0] CSR_ITERATIONS = 3'd3;
   localparam logic [2:0] CSR_MOVEMENT   = 3'd4;
   localparam logic [2:0] CSR_AUDIO      = 3'd5;
   localparam logic [2:0] CSR_FRAME_W    = 3'd6;
   localparam logic [2:0] CSR_FRAME_H    = 3'd7;

   localparam logic [ACT_W-1:0] ONE_Q16   = 17'd65536;
   localparam logic [ACT_W-1:0] HALF_Q16  = 17'd32768;
   // ceil(2^24/d): exact floor division for dividends below 2^20
   localparam logic [22:0] RECIP3    = 23'd5592406;
   localparam logic [21:0] RECIP5    = 22'd3355444;
   // ceil(2^36/765), applied to the channel sum with a 20-bit shift
   localparam logic [26:0] RECIP765  = 27'd89829382;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [IDX_W-1:0] tile_row;
      logic [IDX_W-1:0] tile_col;
      logic [CH_W-1:0]  blue;
      logic [CH_W-1:0]  green;
      logic [CH_W-1:0]  red;
   } req_item_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [CORNER_W-1:0] left;
      logic [CORNER_W-1:0] top;
      logic [CORNER_W-1:0] right;
      logic [CORNER_W-1:0] bottom;
      logic [CH_W-1:0]     out_blue;
      logic [CH_W-1:0]     out_green;
      logic [CH_W-1:0]     out_red;
      logic                border;
   } rsp_item_type;

   typedef struct packed {
      logic             busy;
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] cols;
   } grid_dims_type;

   function automatic logic [SUM_W-1:0] div3(input logic [SUM_W-1:0] x);
      logic [42:0] p;
      p = 43'(x) * 43'(RECIP3);
      return SUM_W'(p[42:24]);
   endfunction

   function automatic logic [SUM_W-1:0] div5(input logic [SUM_W-1:0] x);
      logic [41:0] p;
      p = 42'(x) * 42'(RECIP5);
      return SUM_W'(p[41:24]);
   endfunction

endpackage

// ----- design/tag_grid.sv -----
// Grid size unit: rows = frame_height / edge and cols = frame_width / edge,
// one quotient bit per cycle for both. Depends on tag_pkg.
module tag_grid (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tag_pkg::TS_W-1:0]    ts,
   input  logic [tag_pkg::DIM_W-1:0]   fw,
   input  logic [tag_pkg::DIM_W-1:0]   fh,
   output tag_pkg::grid_dims_type      dims
);
   import tag_pkg::*;

   logic             busy_ff, busy_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [TS_W:0]    remr_ff, remr_in, remc_ff, remc_in;
   logic [DIM_W-1:0] qr_ff, qr_in, qc_ff, qc_in;
   logic [TS_W:0]    tr, tc;
   logic             ger, gec;

   always_comb begin
      tr  = {remr_ff[TS_W-1:0], qr_ff[DIM_W-1]};
      tc  = {remc_ff[TS_W-1:0], qc_ff[DIM_W-1]};
      ger = tr >= {1'b0, ts};
      gec = tc >= {1'b0, ts};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      remr_in = remr_ff;
      remc_in = remc_ff;
      qr_in   = qr_ff;
      qc_in   = qc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 4'(DIM_W - 1);
         remr_in = '0;
         remc_in = '0;
         qr_in   = fh;
         qc_in   = fw;
      end else if (busy_ff) begin
         remr_in = ger ? tr - {1'b0, ts} : tr;
         remc_in = gec ? tc - {1'b0, ts} : tc;
         qr_in   = {qr_ff[DIM_W-2:0], ger};
         qc_in   = {qc_ff[DIM_W-2:0], gec};
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      remr_ff <= remr_in;
      remc_ff <= remc_in;
      qr_ff   <= qr_in;
      qc_ff   <= qc_in;
   end

   assign dims.busy = busy_ff;
   assign dims.rows = qr_ff;
   assign dims.cols = qc_ff;

endmodule

// ----- design/tag_rect.sv -----
// Tile read datapath: rectangle corners, dimmed colour and border flag from
// one tile's activation and colour, three register stages. Depends on tag_pkg.
module tag_rect (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tag_pkg::ACT_W-1:0]    a,
   input  logic [3*tag_pkg::CH_W-1:0]   c,
   input  logic [tag_pkg::IDX_W-1:0]    row,
   input  logic [tag_pkg::IDX_W-1:0]    col,
   input  logic [tag_pkg::TS_W-1:0]     ts,
   input  logic [tag_pkg::MOVE_W-1:0]   movement,
   input  logic [tag_pkg::AUD_W-1:0]    audio,
   input  logic [tag_pkg::THR_W-1:0]    thr,
   input  logic [tag_pkg::DIM_W-1:0]    fw,
   input  logic [tag_pkg::DIM_W-1:0]    fh,
   output logic                         done,
   output tag_pkg::rsp_item_type        res
);
   import tag_pkg::*;

   logic v1_ff, v2_ff, v3_ff;

   // stage 1
   logic             neg_ff, neg_in, bord_ff, bord_in;
   logic [32:0]      p1_ff, p1_in;
   logic [30:0]      num_ff, num_in;
   logic [20:0]      mult_ff, mult_in;
   logic [ACT_W-1:0] mag;

   // stage 2
   logic [41:0]      p2_ff, p2_in;
   logic [8:0]       half_ff, half_in;
   logic [28:0]      cpb_ff, cpb_in, cpg_ff, cpg_in, cpr_ff, cpr_in;
   logic [15:0]      colts_ff, colts_in, rowts_ff, rowts_in;
   logic [SUM_W-1:0] sz;
   logic [9:0]       szc;

   // stage 3
   rsp_item_type     res_ff, res_in;
   logic [11:0]      offx, offy;
   logic signed [20:0] cx, cy, hs;

   function automatic logic [CORNER_W-1:0] corner(input logic signed [20:0] v,
                                                  input logic [DIM_W-1:0] dim);
      logic signed [20:0] hi, w;
      hi = $signed(21'(dim)) - 21'sd1;
      w  = v;
      if (w > hi) w = hi;
      if (w < 21'sd0) w = 21'sd0;
      if (w > 21'sd4095) w = 21'sd4095;
      return w[CORNER_W-1:0];
   endfunction

   always_comb begin
      neg_in  = a < HALF_Q16;
      mag     = neg_in ? HALF_Q16 - a : a - HALF_Q16;
      p1_in   = 33'(mag) * 33'(movement);
      num_in  = 31'(ts) * (31'd655360 + 31'(a) * 31'd10 + 31'(audio) * 31'd6);
      mult_in = 21'd196608 + 21'(a) * 21'd7;
      bord_in = a > thr;

      p2_in    = 42'(p1_ff) * 42'(ts);
      sz       = div5(SUM_W'(num_ff[30:18]));
      if (sz < 20'd2) begin
         szc = 10'd2;
      end else if (sz > 20'({ts, 1'b0})) begin
         szc = {ts, 1'b0};
      end else begin
         szc = sz[9:0];
      end
      half_in  = szc[9:1];
      cpb_in   = 29'(c[7:0]) * 29'(mult_ff);
      cpg_in   = 29'(c[15:8]) * 29'(mult_ff);
      cpr_in   = 29'(c[23:16]) * 29'(mult_ff);
      colts_in = 16'(col) * 16'(ts);
      rowts_in = 16'(row) * 16'(ts);

      offx = p2_ff[41:30];
      offy = 12'(p2_ff[41:31]);
      hs   = $signed(21'(half_ff));
      cx   = $signed(21'(colts_ff)) + $signed(21'(ts[TS_W-1:1]))
             + (neg_ff ? -$signed(21'(offx)) : $signed(21'(offx)));
      cy   = $signed(21'(rowts_ff)) + $signed(21'(ts[TS_W-1:1]))
             + (neg_ff ? -$signed(21'(offy)) : $signed(21'(offy)));
      res_in           = res_ff;
      res_in.status    = RSP_TILE;
      res_in.left      = corner(cx - hs, fw);
      res_in.top       = corner(cy - hs, fh);
      res_in.right     = corner(cx + hs, fw);
      res_in.bottom    = corner(cy + hs, fh);
      // c * mult / (10 * 2^16) = floor(floor(c * mult / 2^17) / 5)
      res_in.out_blue  = CH_W'(div5(SUM_W'(cpb_ff[28:17])));
      res_in.out_green = CH_W'(div5(SUM_W'(cpg_ff[28:17])));
      res_in.out_red   = CH_W'(div5(SUM_W'(cpr_ff[28:17])));
      res_in.border    = bord_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (start) begin
         neg_ff  <= neg_in;
         p1_ff   <= p1_in;
         num_ff  <= num_in;
         mult_ff <= mult_in;
         bord_ff <= bord_in;
      end
      if (v1_ff) begin
         p2_ff    <= p2_in;
         half_ff  <= half_in;
         cpb_ff   <= cpb_in;
         cpg_ff   <= cpg_in;
         cpr_ff   <= cpr_in;
         colts_ff <= colts_in;
         rowts_ff <= rowts_in;
      end
      if (v2_ff) begin
         res_ff <= res_in;
      end
   end

   assign done = v3_ff;
   assign res  = res_ff;

endmodule

// ----- design/tile_activation_grid_engine.sv -----
// One transaction at a time; the response can be held back by rsp_stall. Each grid
// update reads the activation memory one entry per cycle, then copies the next-state
// half back, one tile a cycle. Reset clears control and loads register defaults; after
// reset and after every register write req_stall stays high while the grid size
// divider runs. Memories are not cleared.
module tile_activation_grid_engine #(
   parameter int MAX_ROWS = tag_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = tag_pkg::DEF_MAX_COLS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  tag_pkg::req_item_type            req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output tag_pkg::rsp_item_type            rsp_data,
   input  logic                             csr_we,
   input  logic [tag_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tag_pkg::CSR_W-1:0]        csr_wdata
);
   import tag_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int MEM_D = 2 ** (AW + 1);
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int CW    = $clog2(MAX_COLS + 1);

   typedef enum logic [9:0] {
      S_IDLE     = 10'b0000000001,
      S_DECODE   = 10'b0000000010,
      S_LOAD     = 10'b0000000100,
      S_RD_MEM   = 10'b0000001000,
      S_RD_GO    = 10'b0000010000,
      S_RD_CALC  = 10'b0000100000,
      S_RUN_TILE = 10'b0001000000,
      S_RUN_COPY = 10'b0010000000,
      S_COPY_END = 10'b0100000000,
      S_DONE     = 10'b1000000000
   } state_type;

   state_type          state_ff, state_in;
   req_item_type       req_ff, req_in;
   rsp_item_type       res_ff, res_in, rsp_data_ff, rsp_data_in, rect_res;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               gstart_ff;

   logic [TS_W-1:0]    tile_size_ff, tile_size_in;
   logic [THR_W-1:0]   threshold_ff, threshold_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [ITER_W-1:0]  iterations_ff, iterations_in;
   logic [MOVE_W-1:0]  movement_ff, movement_in;
   logic [AUD_W-1:0]   audio_ff, audio_in;
   logic [DIM_W-1:0]   frame_w_ff, frame_w_in, frame_h_ff, frame_h_in;

   logic [RW-1:0]      y_ff, y_in, rows;
   logic [CW-1:0]      x_ff, x_in, cols;
   logic [2:0]         slot_ff, slot_in;
   logic [SUM_W-1:0]   sum_ff, sum_in, avg_raw;
   logic [ACT_W-1:0]   avg_ff, avg_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic               cp_vld_ff, cp_vld_in;
   logic [AW-1:0]      cp_addr_ff, cp_addr_in;

   // lower half: current activation, upper half: next-state activation
   logic [ACT_W-1:0]   act_mem [MEM_D];
   logic [3*CH_W-1:0]  col_mem [DEPTH];
   logic [ACT_W-1:0]   act_rd_ff;
   logic [3*CH_W-1:0]  col_rd_ff;
   logic               act_we, col_we;
   logic [AW:0]        act_waddr, act_raddr;
   logic [AW-1:0]      req_addr, tile_addr;
   logic [ACT_W-1:0]   act_wdata;

   grid_dims_type      dims;
   logic [TS_W-1:0]    ts_eff;
   logic               vert, horz, en_up, en_dn, en_lf, en_rt, in_grid;
   logic               last_x, last_y, rect_done;
   logic [2:0]         nbr_cnt;
   logic [9:0]         ch_sum;
   logic [36:0]        bright_p;
   int                 tile_i;

   function automatic logic [ACT_W-1:0] gain(input logic [ACT_W-1:0] x,
                                             input logic [THR_W-1:0] thr);
      logic [18:0] y;
      if (x < thr) begin
         y = 19'(x >> 1);
      end else begin
         y = 19'(thr) + ((19'(x - thr) * 19'd3) >> 1);
      end
      return (y > 19'(ONE_Q16)) ? ONE_Q16 : y[ACT_W-1:0];
   endfunction

   tag_grid u_grid (
      .clock (clock),
      .reset (reset),
      .start (gstart_ff),
      .ts    (ts_eff),
      .fw    (frame_w_ff),
      .fh    (frame_h_ff),
      .dims  (dims)
   );

   tag_rect u_rect (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_RD_GO),
      .a        (act_rd_ff),
      .c        (col_rd_ff),
      .row      (req_ff.tile_row),
      .col      (req_ff.tile_col),
      .ts       (ts_eff),
      .movement (movement_ff),
      .audio    (audio_ff),
      .thr      (threshold_ff),
      .fw       (frame_w_ff),
      .fh       (frame_h_ff),
      .done     (rect_done),
      .res      (rect_res)
   );

   always_comb begin
      ts_eff = (tile_size_ff < 9'd4) ? 9'd4 : tile_size_ff;
      rows   = (int'(dims.rows) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(dims.rows);
      cols   = (int'(dims.cols) > MAX_COLS) ? CW'(MAX_COLS) : CW'(dims.cols);
      in_grid = (int'(req_ff.tile_row) < int'(rows)) && (int'(req_ff.tile_col) < int'(cols));
      req_addr = AW'(int'(req_ff.tile_row) * MAX_COLS + int'(req_ff.tile_col));

      vert  = (mode_ff == MODE_VERT) || (mode_ff == MODE_FOUR);
      horz  = (mode_ff == MODE_FOUR) || (mode_ff == MODE_HORZ);
      en_up = vert && (y_ff != '0);
      en_dn = vert && (int'(y_ff) + 1 < int'(rows));
      en_lf = horz && (x_ff != '0);
      en_rt = horz && (int'(x_ff) + 1 < int'(cols));
      last_x = int'(x_ff) + 1 >= int'(cols);
      last_y = int'(y_ff) + 1 >= int'(rows);
      nbr_cnt = 3'(en_up) + 3'(en_dn) + 3'(en_lf) + 3'(en_rt);
      tile_i    = int'(y_ff) * MAX_COLS + int'(x_ff);
      tile_addr = AW'(tile_i);

      case (nbr_cnt)
         3'd0:    avg_raw = sum_ff;
         3'd1:    avg_raw = sum_ff >> 1;
         3'd2:    avg_raw = div3(sum_ff);
         3'd3:    avg_raw = sum_ff >> 2;
         default: avg_raw = div5(sum_ff);
      endcase

      ch_sum   = 10'(req_ff.blue) + 10'(req_ff.green) + 10'(req_ff.red);
      bright_p = 37'(ch_sum) * 37'(RECIP765);
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      y_in          = y_ff;
      x_in          = x_ff;
      slot_in       = slot_ff;
      sum_in        = sum_ff;
      avg_in        = avg_ff;
      iter_in       = iter_ff;
      cp_vld_in     = 1'b0;
      cp_addr_in    = cp_addr_ff;
      act_we        = 1'b0;
      act_waddr     = {1'b0, req_addr};
      act_wdata     = bright_p[36:20];
      col_we        = 1'b0;
      act_raddr     = {1'b0, req_addr};

      tile_size_in  = tile_size_ff;
      threshold_in  = threshold_ff;
      mode_in       = mode_ff;
      iterations_in = iterations_ff;
      movement_in   = movement_ff;
      audio_in      = audio_ff;
      frame_w_in    = frame_w_ff;
      frame_h_in    = frame_h_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TILE_SIZE:  tile_size_in  = csr_wdata[TS_W-1:0];
            CSR_THRESHOLD:  threshold_in  = csr_wdata[THR_W-1:0];
            CSR_MODE:       mode_in       = csr_wdata[MODE_W-1:0];
            CSR_ITERATIONS: iterations_in = csr_wdata[ITER_W-1:0];
            CSR_MOVEMENT:   movement_in   = csr_wdata[MOVE_W-1:0];
            CSR_AUDIO:      audio_in      = csr_wdata[AUD_W-1:0];
            CSR_FRAME_W:    frame_w_in    = csr_wdata[DIM_W-1:0];
            CSR_FRAME_H:    frame_h_in    = csr_wdata[DIM_W-1:0];
            default:        ;
         endcase
      end

      // copy pass: write back the next-state entry read in the previous cycle
      if (cp_vld_ff) begin
         act_we    = 1'b1;
         act_waddr = {1'b0, cp_addr_ff};
         act_wdata = act_rd_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               req_in   = req_data;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_in = '0;
            case (req_ff.req_type)
               REQ_LOAD: begin
                  if (in_grid) begin
                     state_in = S_LOAD;
                  end else begin
                     res_in.status = RSP_BAD_INDEX;
                     state_in      = S_DONE;
                  end
               end
               REQ_READ: begin
                  if (in_grid) begin
                     state_in = S_RD_MEM;
                  end else begin
                     res_in.status = RSP_BAD_INDEX;
                     state_in      = S_DONE;
                  end
               end
               REQ_RUN: begin
                  res_in.status = RSP_RUN_DONE;
                  if (rows == '0 || cols == '0 || iterations_ff == '0) begin
                     state_in = S_DONE;
                  end else begin
                     iter_in  = iterations_ff;
                     y_in     = '0;
                     x_in     = '0;
                     slot_in  = '0;
                     state_in = S_RUN_TILE;
                  end
               end
               default: begin
                  res_in.status = RSP_BAD_INDEX;
                  state_in      = S_DONE;
               end
            endcase
         end
         S_LOAD: begin
            act_we        = 1'b1;
            col_we        = 1'b1;
            res_in.status = RSP_LOADED;
            state_in      = S_DONE;
         end
         S_RD_MEM: state_in = S_RD_GO;
         S_RD_GO:  state_in = S_RD_CALC;
         S_RD_CALC: begin
            if (rect_done) begin
               res_in   = rect_res;
               state_in = S_DONE;
            end
         end
         S_RUN_TILE: begin
            // slots 0..4 issue self, up, down, left, right; slots 1..5 sum the registered read data
            slot_in = slot_ff + 3'd1;
            case (slot_ff)
               3'd1:    act_raddr = {1'b0, en_up ? AW'(tile_i - MAX_COLS) : tile_addr};
               3'd2:    act_raddr = {1'b0, en_dn ? AW'(tile_i + MAX_COLS) : tile_addr};
               3'd3:    act_raddr = {1'b0, en_lf ? AW'(tile_i - 1) : tile_addr};
               3'd4:    act_raddr = {1'b0, en_rt ? AW'(tile_i + 1) : tile_addr};
               default: act_raddr = {1'b0, tile_addr};
            endcase
            case (slot_ff)
               3'd1:    sum_in = SUM_W'(act_rd_ff);
               3'd2:    sum_in = en_up ? sum_ff + SUM_W'(act_rd_ff) : sum_ff;
               3'd3:    sum_in = en_dn ? sum_ff + SUM_W'(act_rd_ff) : sum_ff;
               3'd4:    sum_in = en_lf ? sum_ff + SUM_W'(act_rd_ff) : sum_ff;
               3'd5:    sum_in = en_rt ? sum_ff + SUM_W'(act_rd_ff) : sum_ff;
               default: sum_in = sum_ff;
            endcase
            if (slot_ff == 3'd6) begin
               avg_in = gain(avg_raw[ACT_W-1:0], threshold_ff);
            end
            if (slot_ff == 3'd7) begin
               act_we    = 1'b1;
               act_waddr = {1'b1, tile_addr};
               act_wdata = avg_ff;
               if (!last_x) begin
                  x_in = x_ff + CW'(1);
               end else begin
                  x_in = '0;
                  if (!last_y) begin
                     y_in = y_ff + RW'(1);
                  end else begin
                     y_in     = '0;
                     state_in = S_RUN_COPY;
                  end
               end
            end
         end
         S_RUN_COPY: begin
            act_raddr  = {1'b1, tile_addr};
            cp_vld_in  = 1'b1;
            cp_addr_in = tile_addr;
            if (!last_x) begin
               x_in = x_ff + CW'(1);
            end else begin
               x_in = '0;
               if (!last_y) begin
                  y_in = y_ff + RW'(1);
               end else begin
                  y_in     = '0;
                  state_in = S_COPY_END;
               end
            end
         end
         S_COPY_END: begin
            if (iter_ff == ITER_W'(1)) begin
               state_in = S_DONE;
            end else begin
               iter_in  = iter_ff - ITER_W'(1);
               state_in = S_RUN_TILE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         gstart_ff     <= 1'b1;
         cp_vld_ff     <= 1'b0;
         tile_size_ff  <= 9'd20;
         threshold_ff  <= 17'd32768;
         mode_ff       <= MODE_FOUR;
         iterations_ff <= 6'd5;
         movement_ff   <= 16'd4915;
         audio_ff      <= '0;
         frame_w_ff    <= 13'd640;
         frame_h_ff    <= 13'd480;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         gstart_ff     <= csr_we;
         cp_vld_ff     <= cp_vld_in;
         tile_size_ff  <= tile_size_in;
         threshold_ff  <= threshold_in;
         mode_ff       <= mode_in;
         iterations_ff <= iterations_in;
         movement_ff   <= movement_in;
         audio_ff      <= audio_in;
         frame_w_ff    <= frame_w_in;
         frame_h_ff    <= frame_h_in;
      end
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      y_ff        <= y_in;
      x_ff        <= x_in;
      slot_ff     <= slot_in;
      sum_ff      <= sum_in;
      avg_ff      <= avg_in;
      iter_ff     <= iter_in;
      cp_addr_ff  <= cp_addr_in;
   end

   always_ff @(posedge clock) begin
      if (act_we) begin
         act_mem[act_waddr] <= act_wdata;
      end
      act_rd_ff <= act_mem[act_raddr];
   end

   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[req_addr] <= {req_ff.red, req_ff.green, req_ff.blue};
      end
      col_rd_ff <= col_mem[req_addr];
   end

   assign req_stall = (state_ff != S_IDLE) || gstart_ff || dims.busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- design/tag_checker.sv -----
// Port-level checks for the tile activation grid engine, bound to the top
// level. Depends on the top level's port names only.
module tag_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic csr_we
);

   // one transaction in flight: acceptance closes the input side
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction accepted while one is in flight");

   // register write triggers a grid size recompute
   a_csr_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> req_stall)
      else $error("input not held off after register write");

   a_reset_blocks: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("input open right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule

bind tile_activation_grid_engine tag_checker u_tag_checker (.*);
